// ===== sv/url_field_splitter_core_defines.svh =====
// Assertion macros used by the checker file of url_field_splitter_core.
// Expects clk and arst_n in the scope where they are used.
`ifndef URL_FIELD_SPLITTER_CORE_DEFINES_SVH
`define URL_FIELD_SPLITTER_CORE_DEFINES_SVH
// Same-cycle implication.
`define UFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("url splitter check failed");
// Next-cycle implication.
`define UFS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("url splitter check failed");
`endif

// ===== sv/ufs_pkg.sv =====
// Shared types and constants of the URL field splitter.
// No dependencies.
package ufs_pkg;
	localparam int PORT_TEXT_SIZE = 8;
	localparam int SIZE_W = 9;

	localparam logic [2:0] CFG_PROTOCOL_SIZE = 3'd0;
	localparam logic [2:0] CFG_USERNAME_SIZE = 3'd1;
	localparam logic [2:0] CFG_PASSWORD_SIZE = 3'd2;
	localparam logic [2:0] CFG_HOSTNAME_SIZE = 3'd3;
	localparam logic [2:0] CFG_PATH_SIZE     = 3'd4;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_NO_SCHEME  = 4'd1;
	localparam logic [3:0] ST_PROTO_LONG = 4'd2;
	localparam logic [3:0] ST_USER_LONG  = 4'd3;
	localparam logic [3:0] ST_PASS_LONG  = 4'd4;
	localparam logic [3:0] ST_NO_SLASH   = 4'd5;
	localparam logic [3:0] ST_HOST_LONG  = 4'd6;
	localparam logic [3:0] ST_BAD_PORT   = 4'd7;
	localparam logic [3:0] ST_PATH_LONG  = 4'd8;
	localparam logic [3:0] ST_OVERFLOW   = 4'd9;

	typedef struct packed {
		logic take;  // a character transaction is accepted
		logic calc;  // evaluate the split and load the result
	} ufs_cmd_t;
endpackage

// ===== sv/ufs_ctrl.sv =====
// Controller of the URL field splitter: accept/evaluate sequencing and result strobe.
// Depends on ufs_pkg.
module ufs_ctrl
	import ufs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     is_last,
	output logic     busy,
	output logic     done,
	output ufs_cmd_t cmd
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_CALC = 1'b1;

	logic state_q;
	logic done_q;

	assign busy     = (state_q == S_CALC);
	assign cmd.take = start && !busy;
	assign cmd.calc = busy;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_CALC);
			unique case (state_q)
				S_IDLE: begin
					if (cmd.take && is_last) state_q <= S_CALC;
				end
				S_CALC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/ufs_datapath.sv =====
// Datapath of the URL field splitter: separator trackers, config registers, result.
// Depends on ufs_pkg.
module ufs_datapath
	import ufs_pkg::*;
#(
	parameter int MAX_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ufs_cmd_t    cmd,
	input  logic [7:0]  ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output logic [3:0]  status,
	output logic [8:0]  protocol_len,
	output logic [8:0]  user_start,
	output logic [8:0]  user_len,
	output logic [8:0]  pass_start,
	output logic [8:0]  pass_len,
	output logic [8:0]  host_start,
	output logic [8:0]  host_len,
	output logic [15:0] port_number,
	output logic [8:0]  path_start,
	output logic [8:0]  path_len
);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;

	typedef struct packed {
		logic          slf;  // first '/' seen
		logic [CW-1:0] sl;
		logic          cof;  // ':' seen before the '/'
		logic [CW-1:0] co;
		logic [15:0]   pv;   // port value so far
		logic          bad;  // non-digit in port text
	} trk_t;

	function automatic trk_t trk_next(trk_t t, logic [7:0] c, logic [CW-1:0] p);
		trk_t n;
		n = t;
		if (!t.slf) begin
			if (c == 8'h2F) begin
				n.slf = 1'b1;
				n.sl  = p;
			end else if (t.cof) begin
				if (c < 8'h30 || c > 8'h39) n.bad = 1'b1;
				n.pv = (t.pv << 3) + (t.pv << 1) + {8'd0, c - 8'h30};
			end else if (c == 8'h3A) begin
				n.cof = 1'b1;
				n.co  = p;
			end
		end
		return n;
	endfunction

	function automatic logic ge(logic [CW-1:0] len, logic [SIZE_W-1:0] sz);
		logic [LW-1:0] a;
		logic [LW-1:0] b;
		a = LW'(len);
		b = LW'(sz);
		return a >= b;
	endfunction

	logic [8:0] proto_sz_q, user_sz_q, pass_sz_q, host_sz_q, path_sz_q;

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [7:0]    prev1_q, prev2_q;
	logic          pf_q;
	logic [CW-1:0] plen_q, s_q;
	logic          atf_q, c1f_q;
	logic [CW-1:0] at_q, c1_q;
	trk_t          ta_q, tb_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_sz_q <= 9'd8;
			user_sz_q  <= 9'd32;
			pass_sz_q  <= 9'd32;
			host_sz_q  <= 9'd64;
			path_sz_q  <= 9'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROTOCOL_SIZE: proto_sz_q <= cfg_data;
				CFG_USERNAME_SIZE: user_sz_q  <= cfg_data;
				CFG_PASSWORD_SIZE: pass_sz_q  <= cfg_data;
				CFG_HOSTNAME_SIZE: host_sz_q  <= cfg_data;
				CFG_PATH_SIZE:     path_sz_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// character tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			prev1_q <= '0;
			prev2_q <= '0;
			pf_q    <= 1'b0;
			atf_q   <= 1'b0;
			c1f_q   <= 1'b0;
			ta_q    <= '0;
			tb_q    <= '0;
			plen_q  <= '0;
			s_q     <= '0;
			at_q    <= '0;
			c1_q    <= '0;
		end else if (cmd.calc) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			prev1_q <= '0;
			prev2_q <= '0;
			pf_q    <= 1'b0;
			atf_q   <= 1'b0;
			c1f_q   <= 1'b0;
			ta_q    <= '0;
			tb_q    <= '0;
		end else if (cmd.take) begin
			if (cnt_q == CW'(MAX_LEN)) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q   <= cnt_q + 1'b1;
				prev1_q <= ch;
				prev2_q <= prev1_q;
				if (!pf_q) begin
					if (ch == 8'h2F && prev1_q == 8'h2F && prev2_q == 8'h3A) begin
						pf_q   <= 1'b1;
						plen_q <= cnt_q - CW'(2);
						s_q    <= cnt_q + 1'b1;
					end
				end else begin
					if (!c1f_q && ch == 8'h3A) begin
						c1f_q <= 1'b1;
						c1_q  <= cnt_q;
					end
					if (!atf_q) begin
						ta_q <= trk_next(ta_q, ch, cnt_q);
						if (ch == 8'h40) begin
							atf_q <= 1'b1;
							at_q  <= cnt_q;
						end
					end else begin
						tb_q <= trk_next(tb_q, ch, cnt_q);
					end
				end
			end
		end
	end

	// evaluation
	trk_t          t;
	logic          ucolon;
	logic [CW-1:0] ulen, pwlen, hs, hlen, portl, ps, pathl;
	logic [3:0]    st;

	always_comb begin
		t      = atf_q ? tb_q : ta_q;
		ucolon = c1f_q && (c1_q < at_q);
		ulen   = ucolon ? (c1_q - s_q) : (at_q - s_q);
		pwlen  = at_q - c1_q - 1'b1;
		hs     = atf_q ? (at_q + 1'b1) : s_q;
		hlen   = (t.cof ? t.co : t.sl) - hs;
		portl  = t.sl - t.co - 1'b1;
		ps     = t.sl + 1'b1;
		pathl  = cnt_q - ps;
		priority if (ovf_q)                             st = ST_OVERFLOW;
		else if (!pf_q)                                 st = ST_NO_SCHEME;
		else if (ge(plen_q, proto_sz_q))                st = ST_PROTO_LONG;
		else if (atf_q && ge(ulen, user_sz_q))          st = ST_USER_LONG;
		else if (atf_q && ucolon && ge(pwlen, pass_sz_q)) st = ST_PASS_LONG;
		else if (!t.slf)                                st = ST_NO_SLASH;
		else if (ge(hlen, host_sz_q))                   st = ST_HOST_LONG;
		else if (t.cof && (portl == '0 || t.bad ||
			LW'(portl) >= LW'(PORT_TEXT_SIZE)))        st = ST_BAD_PORT;
		else if (ge(pathl, path_sz_q))                  st = ST_PATH_LONG;
		else                                            st = ST_OK;
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			status <= st;
			if (st == ST_OK) begin
				protocol_len <= 9'(plen_q);
				user_start   <= atf_q ? 9'(s_q) : 9'd0;
				user_len     <= atf_q ? 9'(ulen) : 9'd0;
				pass_start   <= (atf_q && ucolon) ? 9'(c1_q + 1'b1) : 9'd0;
				pass_len     <= (atf_q && ucolon) ? 9'(pwlen) : 9'd0;
				host_start   <= 9'(hs);
				host_len     <= 9'(hlen);
				port_number  <= t.cof ? t.pv : 16'd0;
				path_start   <= 9'(ps);
				path_len     <= 9'(pathl);
			end else begin
				protocol_len <= '0;
				user_start   <= '0;
				user_len     <= '0;
				pass_start   <= '0;
				pass_len     <= '0;
				host_start   <= '0;
				host_len     <= '0;
				port_number  <= '0;
				path_start   <= '0;
				path_len     <= '0;
			end
		end
	end
endmodule

// ===== sv/url_field_splitter_core.sv =====
// Top level of the URL field splitter: controller plus datapath.
// Depends on ufs_pkg, ufs_ctrl and ufs_datapath.
//
// Usage:
//  - Input: drive one URL character on ch with is_last marking the final one,
//    and raise start. A transaction is taken at an edge with start high and
//    busy low. Characters may follow back to back, one per cycle.
//  - Separators are tracked as characters arrive, so no buffer scan is needed.
//  - After the last character busy rises for exactly one cycle while the
//    split is evaluated; the next cycle done pulses for one cycle with status
//    and all part positions valid. busy is low again in that done cycle.
//  - Characters are accepted back to back; no new character is taken while
//    busy is high for the evaluation of a URL.
//  - The receiver cannot stall: sample results in the done cycle; they hold
//    until the next URL finishes.
//  - Configuration: cfg_we, cfg_index, cfg_data write the size limits; write
//    only while no URL is in progress. Reset restores the default limits.
//  - Reset clears the character count, overflow flag and separator trackers.
//  - A URL longer than MAX_LEN drops the extra characters and reports overflow.
module url_field_splitter_core
	import ufs_pkg::*;
#(
	parameter int MAX_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  ch,
	input  logic        is_last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        done,
	output logic [3:0]  status,
	output logic [8:0]  protocol_len,
	output logic [8:0]  user_start,
	output logic [8:0]  user_len,
	output logic [8:0]  pass_start,
	output logic [8:0]  pass_len,
	output logic [8:0]  host_start,
	output logic [8:0]  host_len,
	output logic [15:0] port_number,
	output logic [8:0]  path_start,
	output logic [8:0]  path_len
);
	ufs_cmd_t cmd;

	// sequence transactions and the evaluate cycle
	ufs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.is_last (is_last),
		.busy    (busy),
		.done    (done),
		.cmd     (cmd)
	);

	// track separators, hold limits, build the result
	ufs_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.ch           (ch),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.protocol_len (protocol_len),
		.user_start   (user_start),
		.user_len     (user_len),
		.pass_start   (pass_start),
		.pass_len     (pass_len),
		.host_start   (host_start),
		.host_len     (host_len),
		.port_number  (port_number),
		.path_start   (path_start),
		.path_len     (path_len)
	);
endmodule

// ===== sv/url_field_splitter_core_checker.sv =====
// Port-level checks for url_field_splitter_core, bound to the top level.
// Depends on url_field_splitter_core_defines.svh.
`include "url_field_splitter_core_defines.svh"
module url_field_splitter_core_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       is_last,
	input logic       done,
	input logic [3:0] status
);
	`UFS_ASSERT_NXT(a_busy_one, busy, !busy && done)
	`UFS_ASSERT_IMP(a_done_after_busy, done, $past(busy))
	`UFS_ASSERT_NXT(a_last_busy, start && !busy && is_last, busy)
	`UFS_ASSERT_IMP(a_status_range, done, status <= 4'd9)
endmodule

bind url_field_splitter_core url_field_splitter_core_checker u_chk (.*);
